>>> hdl/pal_pkg.sv
// shared types and constants for the positional array list
package pal_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int OPC_W     = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_FIND   = 3'd4,
    OP_LENGTH = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;
  } out_item_t;

  // insert/delete strobes and find mode broadcast from the controller to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic find_mode;
  } cell_ctrl_t;

  // search token walking down the row of cells
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  found;
  } scan_tok_t;

endpackage

>>> hdl/pal_cell.sv
// one list entry: shift on insert/delete, merge into the passing search token
module pal_cell import pal_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CMP_W = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CMP_W-1:0]  pos_m1_i,
  input  logic [CMP_W-1:0]  cnt_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o,
  input  scan_tok_t         tok_i,
  output scan_tok_t         tok_o
);

  localparam logic [CMP_W-1:0] IdxC  = CMP_W'(IDX);
  localparam logic [POS_W-1:0] Found = POS_W'(IDX + 1);

  logic [DATA_W-1:0] data_q;
  logic              sel_eq, sel_gt, in_list, hit;
  logic              tok_valid_q;
  scan_tok_t         tok_d, tok_q;

  assign sel_eq  = (IdxC == pos_m1_i);
  assign sel_gt  = (IdxC > pos_m1_i);
  assign in_list = (IdxC < cnt_i);
  assign hit     = ctrl_i.find_mode ? (in_list && (data_q == value_i)) : sel_eq;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.ins && sel_eq) begin
      data_q <= value_i;
    end else if (ctrl_i.ins && sel_gt) begin
      data_q <= left_i;
    end else if (ctrl_i.del && (sel_eq || sel_gt)) begin
      data_q <= right_i;
    end else begin
      data_q <= data_q;
    end
  end

  // first hit along the row wins
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.hit && hit) begin
      tok_d.hit   = 1'b1;
      tok_d.data  = data_q;
      tok_d.found = Found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

  assign data_o = data_q;

endmodule

>>> hdl/positional_array_list_top.sv
// positional array list: row of entry cells with a command controller
// clear, insert, length and refused commands: result registered from the execute state
// read, delete and find: the search token walks one cell per cycle down the row; the
// result is registered from the finish state; one transaction in progress at a time
// the next transaction is taken the cycle after the result is registered
// reset empties the list (count zero); entry contents are not reset
module positional_array_list_top import pal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] DepthC = CMP_W'(DEPTH);

  state_e            state_q, state_d;
  in_item_t          cmd_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  out_item_t         out_q, res;
  logic              out_valid_q;
  scan_tok_t         res_q;
  logic              res_load, scan_start, slot_free;
  cell_ctrl_t        ctrl;

  op_e               op;
  logic [CMP_W-1:0]  pos_ext, pos_m1, cnt_ext, cnt_d_ext;
  logic              rd_ok, ins_ok, needs_scan;

  logic [DATA_W-1:0] data_w [DEPTH];
  scan_tok_t         tok_w  [DEPTH+1];
  logic [DEPTH-1:0]  tok_vld;

  // command decode
  assign op      = op_e'(cmd_q.opcode);
  assign pos_ext = CMP_W'(cmd_q.position);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign cnt_ext = CMP_W'(cnt_q);
  assign rd_ok   = (cmd_q.position != '0) && (pos_ext <= cnt_ext);
  assign ins_ok  = (cmd_q.position != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                   && (cnt_ext < DepthC);
  assign needs_scan = ((op == OP_READ) && rd_ok) || ((op == OP_DELETE) && rd_ok)
                      || (op == OP_FIND);
  assign slot_free  = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (needs_scan) begin
          state_d = ST_SCAN;
        end else if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: if (tok_w[DEPTH].valid) state_d = ST_FIN;
      ST_FIN:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready_o     = 1'b0;
    scan_start     = 1'b0;
    res_load       = 1'b0;
    ctrl.ins       = 1'b0;
    ctrl.del       = 1'b0;
    ctrl.find_mode = (op == OP_FIND);
    cnt_d          = cnt_q;
    res.status         = 1'b0;
    res.read_value     = '0;
    res.found_position = '0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: begin
        scan_start = needs_scan;
        res_load   = !needs_scan && slot_free;
        unique case (op)
          OP_CLEAR:  cnt_d = res_load ? '0 : cnt_q;
          OP_INSERT: begin
            res.status = !ins_ok;
            ctrl.ins   = res_load && ins_ok;
            cnt_d      = ctrl.ins ? cnt_q + CNT_W'(1) : cnt_q;
          end
          OP_DELETE, OP_READ: res.status = 1'b1;
          OP_FIND, OP_LENGTH: res.status = 1'b0;
          default:   res.status = 1'b1;
        endcase
      end
      ST_SCAN: ;
      ST_FIN: begin
        res_load = slot_free;
        if (op == OP_FIND) begin
          res.found_position = res_q.hit ? res_q.found : '0;
        end else begin
          res.read_value = res_q.data;
        end
        ctrl.del = slot_free && (op == OP_DELETE);
        cnt_d    = ctrl.del ? cnt_q - CNT_W'(1) : cnt_q;
      end
      default: ;
    endcase
    cnt_d_ext       = CMP_W'(cnt_d);
    res.list_length = cnt_d_ext[POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_item_i;
    end
    if (state_q == ST_SCAN && tok_w[DEPTH].valid) begin
      res_q <= tok_w[DEPTH];
    end
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // token enters at the head of the row
  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].valid = scan_start;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_head
      assign left = data_w[i];
    end else begin : g_mid_l
      assign left = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = data_w[i];
    end else begin : g_mid_r
      assign right = data_w[i+1];
    end

    pal_cell #(
      .IDX   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .pos_m1_i (pos_m1),
      .cnt_i    (cnt_ext),
      .value_i  (cmd_q.value),
      .left_i   (left),
      .right_i  (right),
      .data_o   (data_w[i]),
      .tok_i    (tok_w[i]),
      .tok_o    (tok_w[i+1])
    );

    assign tok_vld[i] = tok_w[i+1].valid;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(cnt_q) <= DepthC)
    else $error("entry count above depth");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one search token in the row");

  a_token_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start |-> ##DEPTH tok_w[DEPTH].valid)
    else $error("search token did not reach the tail on time");

  a_del_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.del |-> (cnt_q != '0) && res_q.hit)
    else $error("delete on empty list or without a located entry");

endmodule

>>> tb/sv/list_checker.sv
`timescale 1ns / 1ps
// checker: shadow list, per-command result prediction and in-order result comparison
module list_checker import pal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count;
  out_item_t                awaited_replies [$];
  out_item_t                oldest_reply;
  int                       errors;

  // applies one command to the shadow list and returns the reply it should produce
  function automatic out_item_t execute_command(input in_item_t cmd);
    out_item_t rsp;
    int        pos;
    int        j;
    rsp = '0;
    pos = cmd.position;
    case (cmd.opcode)
      OP_CLEAR: begin
        shadow_count = 0;
      end
      OP_INSERT: begin
        if (pos < 1 || pos > shadow_count + 1 || shadow_count >= DEPTH) begin
          rsp.status = 1'b1;
        end else begin
          for (j = shadow_count; j >= pos; j--) shadow_entries[j] = shadow_entries[j-1];
          shadow_entries[pos-1] = cmd.value;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > shadow_count) begin
          rsp.status = 1'b1;
        end else begin
          rsp.read_value = shadow_entries[pos-1];
          for (j = pos; j < shadow_count; j++) shadow_entries[j-1] = shadow_entries[j];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (pos < 1 || pos > shadow_count) rsp.status = 1'b1;
        else rsp.read_value = shadow_entries[pos-1];
      end
      OP_FIND: begin
        // walk backward so the first match wins
        for (j = shadow_count - 1; j >= 0; j--) begin
          if (shadow_entries[j] == cmd.value) rsp.found_position = POS_W'(j + 1);
        end
      end
      OP_LENGTH: begin
      end
      default: begin
        rsp.status = 1'b1;
      end
    endcase
    rsp.list_length = POS_W'(shadow_count);
    return rsp;
  endfunction

  function automatic void compare_field(input string field, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      awaited_replies.delete();
      errors = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // results leave before a new command's reply joins the queue
      if (out_valid_i && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item_i);
          errors++;
        end else begin
          oldest_reply = awaited_replies.pop_front();
          compare_field("status", DATA_W'(oldest_reply.status), DATA_W'(out_item_i.status));
          compare_field("read_value", oldest_reply.read_value, out_item_i.read_value);
          compare_field("found_position", DATA_W'(oldest_reply.found_position),
                        DATA_W'(out_item_i.found_position));
          compare_field("list_length", DATA_W'(oldest_reply.list_length),
                        DATA_W'(out_item_i.list_length));
        end
      end
      if (in_valid_i && in_ready_i) awaited_replies.push_back(execute_command(in_item_i));
      pending_o <= awaited_replies.size();
      fail_count_o <= errors;
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, command stimulus, result back-pressure and verdict
module testbench;
  import pal_pkg::*;

  localparam int               DEPTH          = DEPTH_DEF;
  localparam int               WATCHDOG_LIMIT = 2000;
  localparam int               PHASE_ITEMS    = 288;
  localparam logic [OPC_W-1:0] OP_UNDEF_6     = 3'd6;
  localparam logic [OPC_W-1:0] OP_UNDEF_7     = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int pending;
  int fail_count;
  int idle_pct;
  int stall_pct;
  int quiet_cycles = 0;
  int list_fill = 0;
  bit growing = 1'b1;
  int full_linger = 8;

  positional_array_list_top #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** positional_array_list_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sends one command and tracks the list length for position choice
  task automatic issue(input logic [OPC_W-1:0] opc, input int pos,
                       input logic signed [DATA_W-1:0] val);
    in_item_t cmd;
    cmd.opcode   = opc;
    cmd.position = POS_W'(pos);
    cmd.value    = val;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk); while (!in_ready);
    case (opc)
      OP_CLEAR: list_fill = 0;
      OP_INSERT: if (pos >= 1 && pos <= list_fill + 1 && list_fill < DEPTH) list_fill++;
      OP_DELETE: if (pos >= 1 && pos <= list_fill) list_fill--;
      default: ;
    endcase
  endtask

  // hold off new commands until every reply is back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // small pool makes finds hit and repeats common
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 4) return DATA_W'(int'($urandom_range(15)) - 8);
    if (r < 6) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_command();
    int               r;
    int               pos;
    int               pos_hi;
    logic [OPC_W-1:0] opc;
    r = $urandom_range(99);
    if (growing) begin
      if (r < 72) opc = OP_INSERT;
      else if (r < 78) opc = OP_DELETE;
      else if (r < 86) opc = OP_READ;
      else if (r < 94) opc = OP_FIND;
      else if (r < 97) opc = OP_LENGTH;
      else if (r < 99) opc = $urandom_range(1) ? OP_UNDEF_6 : OP_UNDEF_7;
      else opc = OP_INSERT;
    end else begin
      if (r < 55) opc = OP_DELETE;
      else if (r < 65) opc = OP_INSERT;
      else if (r < 77) opc = OP_READ;
      else if (r < 89) opc = OP_FIND;
      else if (r < 95) opc = OP_LENGTH;
      else if (r < 98) opc = $urandom_range(1) ? OP_UNDEF_6 : OP_UNDEF_7;
      else if (r < 99) opc = OP_INSERT;
      else opc = OP_CLEAR;
    end
    pos_hi = (opc == OP_INSERT) ? list_fill + 1 : list_fill;
    if (pos_hi > 0 && $urandom_range(99) < 85) begin
      pos = $urandom_range(pos_hi, 1);
      if ($urandom_range(3) == 0) pos = $urandom_range(1) ? 1 : pos_hi;
    end else begin
      pos = $urandom_range(255);
    end
    issue(opc, pos, pick_value());
    // fill to the top, linger on a full list, then drain back to empty
    if (growing && list_fill == DEPTH) begin
      if (full_linger == 0) growing = 1'b0;
      else full_linger--;
    end else if (!growing && list_fill == 0) begin
      growing     = 1'b1;
      full_linger = 8;
    end
  endtask

  initial begin
    int idle_tbl [4];
    int stall_tbl [4];
    idle_tbl  = '{0, 50, 0, 24};
    stall_tbl = '{0, 0, 50, 24};
    idle_pct  = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corner cases
    issue(OP_LENGTH, 0, 0);
    issue(OP_READ, 1, 0);
    issue(OP_DELETE, 1, 0);
    issue(OP_FIND, 0, 0);
    issue(OP_INSERT, 0, 5);
    issue(OP_INSERT, 2, 5);
    // head, tail, middle inserts with extreme values and a duplicate
    issue(OP_INSERT, 1, 32'sh7fff_ffff);
    issue(OP_INSERT, 1, 32'sh8000_0000);
    issue(OP_INSERT, 3, -1);
    issue(OP_INSERT, 2, 0);
    issue(OP_INSERT, 5, -1);
    issue(OP_READ, 5, 0);
    issue(OP_READ, 6, 0);
    issue(OP_READ, 255, 32'shffff_ffff);
    issue(OP_FIND, 0, -1);
    issue(OP_FIND, 0, 32'sh8000_0000);
    issue(OP_FIND, 0, 12345);
    issue(OP_DELETE, 3, 0);
    issue(OP_DELETE, 0, 0);
    issue(OP_DELETE, 4, 0);
    issue(OP_UNDEF_7, 255, -1);
    issue(OP_UNDEF_6, 0, 0);
    issue(OP_CLEAR, 0, 0);
    issue(OP_LENGTH, 0, 0);
    wait_for_drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_tbl[phase];
      stall_pct = stall_tbl[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_command();
        if ($urandom_range(199) == 0) wait_for_drain();
      end
      wait_for_drain();
    end

    stall_pct = 0;
    repeat (DEPTH + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** positional_array_list_top: PASSED **");
    end else begin
      $display("** positional_array_list_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pal_pkg.sv
hdl/pal_cell.sv
hdl/positional_array_list_top.sv
tb/sv/list_checker.sv
tb/sv/testbench.sv
